[sv/hamming_encode_and_syndrome_assert.svh]
// Assertion macros for the Hamming encoder and syndrome block, used by the hes_parity module.
`ifndef HAMMING_ENCODE_AND_SYNDROME_ASSERT_SVH
`define HAMMING_ENCODE_AND_SYNDROME_ASSERT_SVH

`ifndef SYNTH

`define HES_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HES_ASSERT_IMPLY(label, ante, cons, msg)

`define HES_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/hes_pkg.sv]
// Types, constants and helper functions of the Hamming encoder and syndrome block.
package hes_pkg;

    localparam int WORD_W            = 64;
    localparam int POS_W             = 7;
    localparam int CHECK_MAX         = 7;
    localparam int DLEN_W            = 6;
    localparam int CBITS_W           = 3;
    localparam int GROUP_W           = 8;
    localparam int GROUPS            = WORD_W / GROUP_W;
    localparam int TDATA_W           = 80;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int MAX_CODE_BITS_DEF = 64;

    localparam logic [DLEN_W-1:0]  DATA_LENGTH_RESET = 6'd57;
    localparam logic [CBITS_W-1:0] CHECK_BITS_RESET  = 3'd7;

    localparam logic REG_DATA_LENGTH = 1'b0;
    localparam logic REG_CHECK_BITS  = 1'b1;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_CHECK  = 1'b1;

    typedef struct packed {
        logic [DLEN_W-1:0]  data_length;
        logic [CBITS_W-1:0] check_bits;
    } hes_cfg_t;

    typedef struct packed {
        logic                 kind;
        logic [WORD_W-1:0]    vec;
        logic [POS_W-1:0]     code_len;
        logic [CHECK_MAX-1:0] pmask;
    } hes_s1_t;

    typedef struct packed {
        logic                 position_out_of_range;
        logic                 error_found;
        logic [POS_W-1:0]     error_position;
        logic [WORD_W-1:0]    result_value;
    } hes_res_t;

    function automatic logic is_pow2_pos(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Data bit index carried by codeword bit b (position b+1).
    function automatic logic [DLEN_W-1:0] data_index(input int b);
        int p;
        int cnt;
        p   = b + 1;
        cnt = 0;
        for (int k = 0; k < CHECK_MAX; k++)
        begin
            if ((1 << k) <= p)
            begin
                cnt++;
            end
        end
        if (is_pow2_pos(p))
        begin
            return '0;
        end
        return DLEN_W'(p - 1 - cnt);
    endfunction

    function automatic logic [CHECK_MAX-1:0][WORD_W-1:0] make_col_masks();
        logic [CHECK_MAX-1:0][WORD_W-1:0] m;
        for (int i = 0; i < CHECK_MAX; i++)
        begin
            for (int b = 0; b < WORD_W; b++)
            begin
                m[i][b] = 1'(((b + 1) >> i) & 1);
            end
        end
        return m;
    endfunction

    localparam logic [CHECK_MAX-1:0][WORD_W-1:0] COL_MASK = make_col_masks();

endpackage

[sv/hes_cfg.sv]
// Configuration register file with its APB-style port.
module hes_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hes_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [hes_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [hes_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output hes_pkg::hes_cfg_t                 cfg
);
    import hes_pkg::*;

    logic [DLEN_W-1:0]  data_length_reg;
    logic [DLEN_W-1:0]  data_length_next;
    logic [CBITS_W-1:0] check_bits_reg;
    logic [CBITS_W-1:0] check_bits_next;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[CFG_ADDR_W-1];

    always_comb
    begin
        data_length_next = data_length_reg;
        check_bits_next  = check_bits_reg;
        prdata           = '0;
        case (reg_sel)
            REG_DATA_LENGTH:
            begin
                prdata = CFG_DATA_W'(data_length_reg);
                if (wr_en)
                begin
                    data_length_next = pwdata[DLEN_W-1:0];
                end
            end
            REG_CHECK_BITS:
            begin
                prdata = CFG_DATA_W'(check_bits_reg);
                if (wr_en)
                begin
                    check_bits_next = pwdata[CBITS_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_length_reg <= DATA_LENGTH_RESET;
            check_bits_reg  <= CHECK_BITS_RESET;
        end
        else
        begin
            data_length_reg <= data_length_next;
            check_bits_reg  <= check_bits_next;
        end
    end

    assign cfg.data_length = data_length_reg;
    assign cfg.check_bits  = check_bits_reg;

endmodule

[sv/hes_scatter.sv]
// First pipeline stage: data scatter for encode, position masking for check.
module hes_scatter #(
    parameter int MAX_CODE_BITS = hes_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_kind,
    input  logic [hes_pkg::WORD_W-1:0]  in_word,
    input  hes_pkg::hes_cfg_t           cfg,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hes_pkg::hes_s1_t            out_data
);
    import hes_pkg::*;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    hes_s1_t              s1_data_reg;
    hes_s1_t              s1_data_next;
    logic [POS_W-1:0]     len_sum;
    logic [POS_W-1:0]     len_lim;
    logic [POS_W-1:0]     code_len;
    logic [WORD_W-1:0]    posmask;
    logic [WORD_W-1:0]    scat;
    logic [CHECK_MAX-1:0] pmask;

    assign len_sum  = POS_W'(cfg.data_length) + POS_W'(cfg.check_bits);
    assign len_lim  = POS_W'(MAX_CODE_BITS);
    assign code_len = (len_sum > len_lim) ? len_lim : len_sum;

    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            posmask[b] = (POS_W'(b + 1) <= code_len);
            if (is_pow2_pos(b + 1))
            begin
                scat[b] = 1'b0;
            end
            else
            begin
                scat[b] = in_word[data_index(b)] && (data_index(b) < cfg.data_length)
                          && posmask[b];
            end
        end
        for (int i = 0; i < CHECK_MAX; i++)
        begin
            pmask[i] = (CBITS_W'(i) < cfg.check_bits) && ((POS_W'(1) << i) <= code_len);
        end
    end

    always_comb
    begin
        s1_data_next.kind     = in_kind;
        s1_data_next.vec      = (in_kind == KIND_CHECK) ? (in_word & posmask) : scat;
        s1_data_next.code_len = code_len;
        s1_data_next.pmask    = pmask;
        s1_valid_next         = in_ready ? in_valid : s1_valid_reg;
    end

    assign in_ready = !s1_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= s1_data_next;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_data  = s1_data_reg;

endmodule

[sv/hes_parity.sv]
// Second and third pipeline stages: grouped parity trees, syndrome and result assembly.
`include "hamming_encode_and_syndrome_assert.svh"

module hes_parity (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hes_pkg::hes_s1_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hes_pkg::hes_res_t out_data
);
    import hes_pkg::*;

    logic                                 s2_valid_reg;
    logic                                 s2_valid_next;
    logic                                 s2_kind_reg;
    logic [WORD_W-1:0]                    s2_vec_reg;
    logic [POS_W-1:0]                     s2_len_reg;
    logic [CHECK_MAX-1:0]                 s2_pmask_reg;
    logic [CHECK_MAX-1:0][GROUPS-1:0]     s2_part_reg;
    logic [CHECK_MAX-1:0][GROUPS-1:0]     s2_part_next;
    logic                                 s3_valid_reg;
    logic                                 s3_valid_next;
    logic                                 s3_ready;
    hes_res_t                             s3_res_reg;
    hes_res_t                             s3_res_next;
    logic [CHECK_MAX-1:0]                 syn;
    logic [WORD_W-1:0]                    codeword;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign in_ready = !s2_valid_reg || s3_ready;

    always_comb
    begin
        for (int i = 0; i < CHECK_MAX; i++)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                s2_part_next[i][g] =
                    ^(in_data.vec[g*GROUP_W +: GROUP_W] & COL_MASK[i][g*GROUP_W +: GROUP_W]);
            end
        end
        s2_valid_next = in_ready ? in_valid : s2_valid_reg;
    end

    always_comb
    begin
        codeword = s2_vec_reg;
        for (int i = 0; i < CHECK_MAX; i++)
        begin
            syn[i] = (^s2_part_reg[i]) && s2_pmask_reg[i];
            if (syn[i])
            begin
                codeword[(1 << i) - 1] = 1'b1;
            end
        end
        if (s2_kind_reg == KIND_CHECK)
        begin
            s3_res_next.result_value          = '0;
            s3_res_next.error_position        = syn;
            s3_res_next.error_found           = |syn;
            s3_res_next.position_out_of_range = (syn > s2_len_reg);
        end
        else
        begin
            s3_res_next.result_value          = codeword;
            s3_res_next.error_position        = '0;
            s3_res_next.error_found           = 1'b0;
            s3_res_next.position_out_of_range = 1'b0;
        end
        s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s2_kind_reg  <= in_data.kind;
            s2_vec_reg   <= in_data.vec;
            s2_len_reg   <= in_data.code_len;
            s2_pmask_reg <= in_data.pmask;
            s2_part_reg  <= s2_part_next;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_res_reg <= s3_res_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_res_reg;

    `HES_ASSERT_NEXT(a_s2_hold, s2_valid_reg && !s3_ready, s2_valid_reg && $stable(s2_part_reg), "stage two lost a stalled transaction")
    `HES_ASSERT_NEXT(a_s3_hold, s3_valid_reg && !out_ready, s3_valid_reg && $stable(s3_res_reg), "result changed while stalled")
    `HES_ASSERT_IMPLY(a_range_found, s3_valid_reg && s3_res_reg.position_out_of_range, s3_res_reg.error_found, "out of range without error flag")
    `HES_ASSERT_IMPLY(a_check_zero, s3_valid_reg && s3_res_reg.error_found, s3_res_reg.result_value == '0, "check result carries a codeword")
    `HES_ASSERT_IMPLY(a_rise_src, $rose(s3_valid_reg), $past(s2_valid_reg), "result appeared without a source transaction")

endmodule

[sv/hamming_encode_and_syndrome.sv]
// Top level of the pipelined Hamming encoder and syndrome checker.
// Each transaction on the slave side is either an encode (tuser 0: tdata is the data word)
// or a check (tuser 1: tdata is the received codeword, position p at bit p-1). The block
// takes one transaction every cycle unless backpressure fills the pipeline. It has three
// register stages: data scatter and position masking, parity over byte groups, and
// the final parity reduction with result assembly into the output register. Backpressure
// on the master side stalls only the stages that are full, so bubbles close up. The data
// length and check-bit count are set over the APB-style port and should be written only
// while no transaction is in flight.
module hamming_encode_and_syndrome #(
    parameter int MAX_CODE_BITS = hes_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // word[63:0]
    input  logic [hes_pkg::WORD_W-1:0]        s_tdata,
    // kind[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_value[63:0], error_position[70:64], error_found[71],
    // position_out_of_range[72], zero fill[79:73]
    output logic [hes_pkg::TDATA_W-1:0]       m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hes_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [hes_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [hes_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import hes_pkg::*;

    hes_cfg_t cfg;
    logic     s1_valid;
    logic     s1_ready;
    hes_s1_t  s1_data;
    hes_res_t res;

    hes_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hes_scatter #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_scatter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_word   (s_tdata),
        .cfg       (cfg),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    hes_parity u_parity (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = TDATA_W'(res);

endmodule
